### hdl/kssa_pkg.sv
// Shared types and constants of the keyed slot allocator.
package kssa_pkg;

  // Fixed field widths of the streaming and configuration ports.
  localparam int unsigned NATIVE_KEY_W = 64;
  localparam int unsigned LIMIT_W      = 7;
  localparam int unsigned SLOT_NUM_W   = 6;
  localparam int unsigned OUTCOME_W    = 3;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_SLOT_COUNT = 64;
  localparam int unsigned DEF_KEY_BITS   = 64;

  // Request kinds carried in the input tuser bit.
  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  // Result kinds carried in the output tuser bits.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_PRESENT  = 3'd0,
    OUT_ASSIGNED = 3'd1,
    OUT_FULL     = 3'd2,
    OUT_FREED    = 3'd3,
    OUT_ABSENT   = 3'd4
  } outcome_e;

  // One finished result handed from the scan controller to the output stage.
  typedef struct packed {
    logic [SLOT_NUM_W-1:0] slot_number;
    outcome_e              outcome;
  } result_t;

endpackage

### hdl/kssa_slot_mem.sv
// Slot table memory: one write port and one registered read port.
module kssa_slot_mem #(
  parameter int unsigned DEPTH = kssa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned WIDTH = kssa_pkg::DEF_KEY_BITS + 1
) (
  input  logic                                    clk_i,
  input  logic                                    rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                        rd_data_o,
  input  logic                                    wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                        wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### hdl/kssa_scan_ctrl.sv
// Scan controller: clears the table, scans it per request and writes back.
module kssa_scan_ctrl #(
  parameter int unsigned SLOT_COUNT = kssa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned KEY_BITS   = kssa_pkg::DEF_KEY_BITS,
  localparam int unsigned IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          req_action_i,
  input  logic [KEY_BITS-1:0]           req_key_i,
  input  logic [kssa_pkg::LIMIT_W-1:0]  limit_i,
  // Result side.
  input  logic                          res_free_i,
  output logic                          res_valid_o,
  output kssa_pkg::result_t             res_o,
  // Memory ports.
  output logic                          rd_en_o,
  output logic [IDX_W-1:0]              rd_addr_o,
  input  logic [KEY_BITS:0]             rd_data_i,
  output logic                          wr_en_o,
  output logic [IDX_W-1:0]              wr_addr_o,
  output logic [KEY_BITS:0]             wr_data_o
);

  import kssa_pkg::*;

  localparam int unsigned CW = (IDX_W + 1 > LIMIT_W) ? IDX_W + 1 : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    cnt_q;
  logic                action_q;
  logic [KEY_BITS-1:0] key_q;
  logic                cmp_valid_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                hit_found_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_idx_q;

  logic                entry_occ;
  logic                entry_hit;
  logic                entry_free;
  logic                req_fire;
  logic                finish_fire;
  logic [IDX_W+5:0]    hit_ext;
  logic [IDX_W+5:0]    free_ext;
  result_t             result;
  logic                do_write;
  logic [IDX_W-1:0]    target_idx;
  logic                target_occ;

  // Evaluation of the entry returned by the memory in this cycle.
  assign entry_occ  = rd_data_i[KEY_BITS];
  assign entry_hit  = cmp_valid_q && entry_occ && (rd_data_i[KEY_BITS-1:0] == key_q);
  assign entry_free = cmp_valid_q && !entry_occ && (CW'(cmp_idx_q) < CW'(limit_i));

  assign req_ready_o = (state_q == ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign finish_fire = (state_q == ST_FINISH) && res_free_i;

  // Slot numbers are reported modulo 64.
  assign hit_ext  = (IDX_W + 6)'(hit_idx_q);
  assign free_ext = (IDX_W + 6)'(free_idx_q);

  // Decision taken once the whole table has been seen.
  always_comb begin
    result.slot_number = '0;
    result.outcome     = OUT_FULL;
    do_write           = 1'b0;
    target_idx         = hit_idx_q;
    target_occ         = 1'b0;
    if (action_q == ACT_ADD) begin
      if (hit_found_q) begin
        result.slot_number = hit_ext[5:0];
        result.outcome     = OUT_PRESENT;
      end else if (free_found_q) begin
        result.slot_number = free_ext[5:0];
        result.outcome     = OUT_ASSIGNED;
        do_write           = 1'b1;
        target_idx         = free_idx_q;
        target_occ         = 1'b1;
      end
    end else begin
      if (hit_found_q) begin
        result.slot_number = hit_ext[5:0];
        result.outcome     = OUT_FREED;
        do_write           = 1'b1;
      end else begin
        result.outcome = OUT_ABSENT;
      end
    end
  end

  // Memory access: clearing pass, scan reads and the final write-back.
  always_comb begin
    rd_en_o   = (state_q == ST_SCAN);
    rd_addr_o = cnt_q;
    wr_en_o   = 1'b0;
    wr_addr_o = cnt_q;
    wr_data_o = '0;
    if (state_q == ST_CLEAR) begin
      wr_en_o = 1'b1;
    end else if (finish_fire && do_write) begin
      wr_en_o   = 1'b1;
      wr_addr_o = target_idx;
      wr_data_o = {target_occ, key_q};
    end
  end

  assign res_valid_o = finish_fire;
  assign res_o       = result;

  // Sequencer state and scan bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      action_q     <= 1'b0;
      key_q        <= '0;
      cmp_valid_q  <= 1'b0;
      cmp_idx_q    <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
    end else begin
      // A read issued now returns its entry in the next cycle.
      cmp_valid_q <= rd_en_o;
      cmp_idx_q   <= cnt_q;

      // Keep the lowest matching slot and the lowest usable free slot.
      if (entry_hit && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= cmp_idx_q;
      end
      if (entry_free && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end

      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            action_q     <= req_action_i;
            key_q        <= req_key_i;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            cnt_q        <= '0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (res_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted request always starts a scan in the next cycle.
  a_fire_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == ST_SCAN))
    else $error("request accepted but no scan started");

  // The table is never written while it is being scanned.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_DRAIN) |-> !wr_en_o)
    else $error("table written during a scan");

  // No read response is pending while the controller waits for a request.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmp_valid_q)
    else $error("stray read response while idle");

  // A new assignment needs a free slot below the limit and writes the table.
  a_assign_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.outcome == OUT_ASSIGNED) |-> (free_found_q && wr_en_o))
    else $error("assignment without a free slot or write-back");
`endif

endmodule

### hdl/keyed_slot_id_allocator_top.sv
// Top level of the keyed slot allocator: ports, limit register and output stage.
//
// The block maps wide keys to slot numbers. Each request scans the whole slot
// table through one memory read port, one slot per cycle, then passes through
// a drain state and a finish state before its result leaves the controller; a
// new request is taken in the cycle after the result has left the controller,
// even while that result still waits in the output register.
// After reset the table is cleared one slot per cycle, and the input stays not
// ready until the clearing pass is done; limit writes are taken at any time.
module keyed_slot_id_allocator_top #(
  parameter int unsigned SLOT_COUNT = kssa_pkg::DEF_SLOT_COUNT,
  parameter int unsigned KEY_BITS   = kssa_pkg::DEF_KEY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: active slot limit.
  input  logic                             cfg_we_i,
  input  logic [kssa_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  // Request stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [kssa_pkg::NATIVE_KEY_W-1:0] s_axis_tdata,  // [63:0] native_key
  input  logic                             s_axis_tuser,  // [0] action
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [5:0] slot_number, [7:6] zero
  output logic [kssa_pkg::OUTCOME_W-1:0]   m_axis_tuser   // [2:0] outcome
);

  import kssa_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [LIMIT_W-1:0]  limit_q;
  logic                out_valid_q;
  result_t             out_res_q;
  logic                res_free;
  logic                res_valid;
  result_t             res;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_BITS:0]   rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS:0]   wr_data;

  // Active slot limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Output register holds a finished transaction until the sink takes it.
  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.slot_number};
  assign m_axis_tuser  = out_res_q.outcome;

  kssa_scan_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_action_i (s_axis_tuser),
    .req_key_i    (s_axis_tdata[KEY_BITS-1:0]),
    .limit_i      (limit_q),
    .res_free_i   (res_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  kssa_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (KEY_BITS + 1)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule
